// ----- hdl/whmx_pkg.sv -----
// Shared constants, types and helpers for the word multiply xorshift hash unit.
package whmx_pkg;

   localparam int LENGTH_BITS = 32;

   localparam logic [31:0] LEN_MASK = (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << LENGTH_BITS) - 64'd1);

   localparam logic [63:0] K_INIT  = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] K_WORD  = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] K_ROUND = 64'h94D0_49BB_1331_11EB;
   localparam logic [63:0] K_FINAL = 64'hD6E8_FEB8_6659_FD93;

   localparam int MUL_STEPS = 3;

   typedef enum logic [1:0] {
      SEL_INIT,
      SEL_WORD,
      SEL_ROUND,
      SEL_FINAL
   } const_sel_type;

   typedef struct packed {
      logic          start;
      logic [63:0]   operand;
      const_sel_type sel;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

   function automatic logic [63:0] hash_const(const_sel_type sel);
      logic [63:0] k;
      unique case (sel)
         SEL_INIT:  k = K_INIT;
         SEL_WORD:  k = K_WORD;
         SEL_ROUND: k = K_ROUND;
         SEL_FINAL: k = K_FINAL;
         default:   k = K_INIT;
      endcase
      return k;
   endfunction

endpackage

// ----- hdl/word_multiply_xorshift_hash_unit.sv -----
// Word multiply xorshift hash unit: sequencer, hash datapath and result register.
// Each word is taken while the unit is idle; then it stalls its input while the shared
// multiplier works; each 64-bit constant multiply is three 32x32 partial products. A
// middle word does a word then a round multiply, a first word adds a seed and length
// mix first, a tail word does a word then a final multiply, and a full last word does
// word, round and final. The final hash also waits for the result register to be free.
// A word with no message open and without first_word is dropped with no result.
module word_multiply_xorshift_hash_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_first_word,
   input  logic        req_last_word,
   input  logic [31:0] req_message_length,
   input  logic [63:0] req_seed_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value
);
   import whmx_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_WORD,
      ST_ROUND,
      ST_FIN,
      ST_EMIT
   } state_type;

   state_type   state_ff, state_in;
   logic [63:0] hash_ff, hash_in;
   logic        in_msg_ff, in_msg_in;
   logic [63:0] word_ff, word_in;
   logic [3:0]  count_ff, count_in;
   logic        tail_ff, tail_in;
   logic        last_ff, last_in;
   logic [63:0] seed_ff, seed_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_hash_ff, rsp_hash_in;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   logic        accept;
   logic [63:0] byte_mask;
   logic [63:0] mixed;
   logic [63:0] rotated;
   logic [63:0] fin_pre;

   whmx_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         byte_mask[8*i +: 8] = {8{req_valid_bytes[3] || (3'(i) < req_valid_bytes[2:0])}};
      end
   end

   always_comb begin
      if (tail_ff) begin
         mixed = hash_ff ^ (mul_rsp.product + {60'b0, count_ff});
      end else begin
         mixed = hash_ff ^ mul_rsp.product;
      end
      rotated = {mixed[36:0], mixed[63:37]};
      if (state_ff == ST_ROUND) begin
         fin_pre = mul_rsp.product ^ (mul_rsp.product >> 31);
      end else begin
         fin_pre = mixed ^ (mixed >> 31);
      end
   end

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      in_msg_in    = in_msg_ff;
      word_in      = word_ff;
      count_in     = count_ff;
      tail_in      = tail_ff;
      last_in      = last_ff;
      seed_in      = seed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      mul_req      = '{start: 1'b0, operand: 64'd0, sel: SEL_WORD};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               word_in  = req_data_word & byte_mask;
               count_in = req_valid_bytes[3] ? 4'd8 : req_valid_bytes;
               tail_in  = !req_valid_bytes[3];
               last_in  = req_last_word;
               seed_in  = req_seed_value;
               if (req_first_word) begin
                  in_msg_in = 1'b1;
                  mul_req   = '{start: 1'b1,
                                operand: {32'b0, req_message_length & LEN_MASK} + 64'd1,
                                sel: SEL_INIT};
                  state_in  = ST_INIT;
               end else if (in_msg_ff) begin
                  mul_req  = '{start: 1'b1, operand: req_data_word & byte_mask,
                               sel: SEL_WORD};
                  state_in = ST_WORD;
               end
            end
         end
         ST_INIT: begin
            if (mul_rsp.done) begin
               hash_in  = seed_ff ^ mul_rsp.product;
               mul_req  = '{start: 1'b1, operand: word_ff, sel: SEL_WORD};
               state_in = ST_WORD;
            end
         end
         ST_WORD: begin
            if (mul_rsp.done) begin
               if (tail_ff) begin
                  mul_req  = '{start: 1'b1, operand: fin_pre, sel: SEL_FINAL};
                  state_in = ST_FIN;
               end else begin
                  mul_req  = '{start: 1'b1, operand: rotated, sel: SEL_ROUND};
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            if (mul_rsp.done) begin
               hash_in = mul_rsp.product;
               if (last_ff) begin
                  mul_req  = '{start: 1'b1, operand: fin_pre, sel: SEL_FINAL};
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FIN: begin
            if (mul_rsp.done) begin
               hash_in   = mul_rsp.product ^ (mul_rsp.product >> 32);
               in_msg_in = 1'b0;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = hash_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      count_ff    <= count_in;
      tail_ff     <= tail_in;
      last_ff     <= last_in;
      seed_ff     <= seed_in;
      rsp_hash_ff <= rsp_hash_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= 64'd0;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         in_msg_ff    <= in_msg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   a_done_while_waiting: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff != ST_IDLE && state_ff != ST_EMIT))
      else $error("multiplier finished with no operation waiting");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside emit");

   a_orphan_dropped: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_first_word && !in_msg_ff) |=> (state_ff == ST_IDLE))
      else $error("word with no open message was not dropped");

   a_emit_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !in_msg_ff)
      else $error("message still open at emit");

endmodule

// ----- hdl/whmx_mul.sv -----
// Iterative 64 by 64 bit multiplier, low half only, built on one 32 by 32 bit multiplier.
module whmx_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  whmx_pkg::mul_req_type mul_req,
   output whmx_pkg::mul_rsp_type mul_rsp
);
   import whmx_pkg::*;

   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] a_part;
   logic [31:0] b_part;
   logic [63:0] partial;

   always_comb begin
      unique case (cnt_ff)
         2'd0: begin
            a_part = a_ff[31:0];
            b_part = b_ff[31:0];
         end
         2'd1: begin
            a_part = a_ff[31:0];
            b_part = b_ff[63:32];
         end
         default: begin
            a_part = a_ff[63:32];
            b_part = b_ff[31:0];
         end
      endcase
   end

   assign partial = {32'b0, a_part} * {32'b0, b_part};

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         a_in    = mul_req.operand;
         b_in    = hash_const(mul_req.sel);
         acc_in  = 64'd0;
         cnt_in  = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == 2'd0) begin
            acc_in = partial;
         end else begin
            acc_in = acc_ff + {partial[31:0], 32'b0};
         end
         if (cnt_ff == 2'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      if (reset) begin
         cnt_ff  <= 2'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule
